// File: rtl/core/tpi_pkg.sv
// Package for the triangle/plane slicer: coordinate widths, payload structs,
// the edge job passed from front to back, and the back-end state codes.
// No dependencies.
`default_nettype none

package tpi_pkg;

  localparam int CW    = 32;          // coordinate width
  localparam int W     = CW + 1;      // width of a coordinate difference
  localparam int CNT_W = $clog2(W);

  localparam logic [1:0] EDGE_01 = 2'd0;
  localparam logic [1:0] EDGE_12 = 2'd1;
  localparam logic [1:0] EDGE_20 = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
  } tri_t;

  typedef struct packed {
    logic signed [CW-1:0] cut_x;
    logic signed [CW-1:0] cut_y;
    logic [1:0]           edge_index;
    logic                 last_of_triangle;
  } res_t;

  typedef struct packed {
    logic signed [CW-1:0] xa;
    logic signed [CW-1:0] ya;
    logic signed [W-1:0]  dx;
    logic signed [W-1:0]  dy;
    logic signed [W-1:0]  diff;
    logic signed [W-1:0]  dz;
    logic [1:0]           edge_index;
    logic                 last;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

`default_nettype wire

// File: rtl/core/tpi_front.sv
// Front end: takes triangles, finds the edges the plane cuts and issues one
// edge job per cycle into the job queue while the queue is not full.
// Depends on tpi_pkg.
`default_nettype none

module tpi_front
  import tpi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic signed [CW-1:0] plane,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire tri_t                 in_data,
  output logic                      job_push,
  input  wire logic                 job_full,
  output job_t                      job
);

  tri_t       tri_r;
  logic [2:0] mask_r, mask_nxt;
  logic [2:0] sel;
  logic [2:0] rest;
  logic [2:0] new_mask;
  logic       low0, low1, low2, accept;
  logic signed [CW-1:0] xa, ya, za, xb, yb, zb;

  assign low0 = in_data.v0_z <= plane;
  assign low1 = in_data.v1_z <= plane;
  assign low2 = in_data.v2_z <= plane;
  assign new_mask = {low2 != low0, low1 != low2, low0 != low1};

  // lowest pending edge goes first
  assign sel  = mask_r[0] ? 3'b001 : (mask_r[1] ? 3'b010 : 3'b100);
  assign rest = mask_r & ~sel;

  assign job_push = (mask_r != 3'b000) && !job_full;
  assign in_full  = (mask_r != 3'b000) && !(job_push && rest == 3'b000);
  assign accept   = in_push && !in_full;

  always_comb begin
    case (sel)
      3'b001: begin
        xa = tri_r.v0_x; ya = tri_r.v0_y; za = tri_r.v0_z;
        xb = tri_r.v1_x; yb = tri_r.v1_y; zb = tri_r.v1_z;
        job.edge_index = EDGE_01;
      end
      3'b010: begin
        xa = tri_r.v1_x; ya = tri_r.v1_y; za = tri_r.v1_z;
        xb = tri_r.v2_x; yb = tri_r.v2_y; zb = tri_r.v2_z;
        job.edge_index = EDGE_12;
      end
      default: begin
        xa = tri_r.v2_x; ya = tri_r.v2_y; za = tri_r.v2_z;
        xb = tri_r.v0_x; yb = tri_r.v0_y; zb = tri_r.v0_z;
        job.edge_index = EDGE_20;
      end
    endcase
    job.xa   = xa;
    job.ya   = ya;
    job.dx   = W'(xb) - W'(xa);
    job.dy   = W'(yb) - W'(ya);
    job.diff = W'(plane) - W'(za);
    job.dz   = W'(zb) - W'(za);
    job.last = (rest == 3'b000);
  end

  always_comb begin
    mask_nxt = mask_r;
    if (job_push) mask_nxt = rest;
    if (accept)   mask_nxt = new_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 3'b000;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) tri_r <= in_data;
  end

  // a closed triangle is cut on an even number of edges
  a_even_cuts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ($countones(mask_r) == 0 || $countones(mask_r) == 2))
    else $error("odd number of cut edges");
  a_no_accept_with_two: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(mask_r) == 2) |-> !accept)
    else $error("triangle accepted while two edges pending");
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (job_push && job.last) |-> ($countones(mask_r) == 1))
    else $error("last flag on a non-final edge");

endmodule

`default_nettype wire

// File: rtl/core/tpi_queue.sv
// Four-entry queue of edge jobs between the front and back ends.
// Depends on tpi_pkg.
`default_nettype none

module tpi_queue
  import tpi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t din,
  output logic      full,
  input  wire logic rd_en,
  output job_t      dout,
  output logic      empty
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r;
  logic          do_wr, do_rd;

  assign full  = count_r == (AW+1)'(DEPTH);
  assign empty = count_r == '0;
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign dout  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[AW-1:0])
    else $error("queue pointers disagree with count");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> (count_r == (AW+1)'(DEPTH)) || $past(do_rd))
    else $error("queue changed while full without a read");

endmodule

`default_nettype wire

// File: rtl/core/tpi_back.sv
// Back end: for each edge job multiplies the differences, divides by dz one
// quotient bit a cycle (x and y side by side) and holds the point for pop.
// Depends on tpi_pkg.
`default_nettype none

module tpi_back
  import tpi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_empty,
  output logic      job_pop,
  input  wire job_t job,
  output logic      out_empty,
  input  wire logic out_pop,
  output res_t      out_data
);

  bk_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  res_t             out_r;

  logic signed [CW-1:0] xa_r, ya_r;
  logic [W-1:0] mdx_r, mdy_r, mdiff_r, mdz_r;
  logic         negx_r, negy_r, last_r;
  logic [1:0]   edge_r;
  logic [W-1:0] remx_r, remy_r, shx_r, shy_r;

  logic [2*W-1:0] px, py;
  logic [W:0]     tx, ty;
  logic           load_out, out_free;
  logic signed [CW-1:0] qx, qy;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? W'(-v) : W'(v);
  endfunction

  assign out_free = !out_valid_r || out_pop;
  assign px = mdx_r * mdiff_r;
  assign py = mdy_r * mdiff_r;
  assign tx = {remx_r, shx_r[W-1]};
  assign ty = {remy_r, shy_r[W-1]};
  assign qx = shx_r[CW-1:0];
  assign qy = shy_r[CW-1:0];

  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: state_nxt = BK_DIV;
      BK_DIV: begin
        if (cnt_r == CNT_W'(W-1)) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_DIV) cnt_r <= cnt_r + 1'b1;
      else                   cnt_r <= '0;
      if (load_out)     out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        xa_r    <= job.xa;
        ya_r    <= job.ya;
        mdx_r   <= mag(job.dx);
        mdy_r   <= mag(job.dy);
        mdiff_r <= mag(job.diff);
        mdz_r   <= mag(job.dz);
        negx_r  <= job.dx[W-1] ^ job.diff[W-1] ^ job.dz[W-1];
        negy_r  <= job.dy[W-1] ^ job.diff[W-1] ^ job.dz[W-1];
        edge_r  <= job.edge_index;
        last_r  <= job.last;
      end
      BK_MUL: begin
        // quotient fits W bits, so the high half already sits below dz
        remx_r <= px[2*W-1:W];
        shx_r  <= px[W-1:0];
        remy_r <= py[2*W-1:W];
        shy_r  <= py[W-1:0];
      end
      BK_DIV: begin
        if (tx >= {1'b0, mdz_r}) begin
          remx_r <= W'(tx - {1'b0, mdz_r});
          shx_r  <= {shx_r[W-2:0], 1'b1};
        end else begin
          remx_r <= tx[W-1:0];
          shx_r  <= {shx_r[W-2:0], 1'b0};
        end
        if (ty >= {1'b0, mdz_r}) begin
          remy_r <= W'(ty - {1'b0, mdz_r});
          shy_r  <= {shy_r[W-2:0], 1'b1};
        end else begin
          remy_r <= ty[W-1:0];
          shy_r  <= {shy_r[W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_r.cut_x            <= negx_r ? xa_r - qx : xa_r + qx;
      out_r.cut_y            <= negy_r ? ya_r - qy : ya_r + qy;
      out_r.edge_index       <= edge_r;
      out_r.last_of_triangle <= last_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  a_edge_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.edge_index != 2'd3))
    else $error("bad edge index on output");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (cnt_r <= CNT_W'(W-1)))
    else $error("divider ran past its length");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_pop))
    else $error("result overwritten before transfer");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (state_r == BK_IDLE) && !job_empty)
    else $error("job taken while busy");

endmodule

`default_nettype wire

// File: rtl/core/triangle_plane_intersect.sv
// Triangle/plane slicer. Front end accepts a triangle each cycle it is free and
// issues an even number of edge jobs, one per cycle while queue has room; back
// end handles each edge in a multiply state, a bit-serial divide and a load
// into its output register, and takes no new edge job until that point has
// been loaded, so the bit-serial divider limits throughput.
// Synchronous active-low reset empties the queues; plane height resets to 0.
`default_nettype none

module triangle_plane_intersect
  import tpi_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_data,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire tri_t          in_data,
  output logic               out_empty,
  input  wire logic          out_pop,
  output res_t               out_data
);

  logic signed [CW-1:0] plane_r;
  job_t front_job, back_job;
  logic job_push, job_full, job_pop, job_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_we) begin
      plane_r <= cfg_data;
    end
  end

  tpi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .plane    (plane_r),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .job_push (job_push),
    .job_full (job_full),
    .job      (front_job)
  );

  tpi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (job_push),
    .din   (front_job),
    .full  (job_full),
    .rd_en (job_pop),
    .dout  (back_job),
    .empty (job_empty)
  );

  tpi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (back_job),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for triangle_plane_intersect: drives triangles and
// plane heights and checks every cut point against typed values or a built-in predictor.
// Depends on tpi_pkg and the triangle_plane_intersect RTL.
`timescale 1ns / 100ps

module tb
  import tpi_pkg::*;
();

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [CW-1:0] cfg_data;
  logic          in_push;
  logic          in_full;
  tri_t          in_data;
  logic          out_empty;
  logic          out_pop;
  res_t          out_data;

  triangle_plane_intersect uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  typedef struct {
    tri_t tri_in;
    int   n_pts;     // -1: expectation comes from the predictor
    res_t pt0;
    res_t pt1;
  } dir_row_t;

  res_t                 cut_pts_q[$];
  logic signed [CW-1:0] plane_z;
  int                   errors;
  int                   tris_sent;
  int                   pts_checked;
  bit                   hold_out;
  bit                   quiet;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("** triangle_plane_intersect: FAILED **");
    $finish;
  end

  task automatic mismatch(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Queue one expected point at the tail.
  function automatic void add_pt(res_t p);
    cut_pts_q.insert(cut_pts_q.size(), p);
  endfunction

  // Append the points this triangle should produce at the current plane.
  function automatic void slice_tri(tri_t t);
    logic signed [CW-1:0] xs[3], ys[3], zs[3];
    logic signed [99:0]   xa, ya, za, dx, dy, dz, diff;
    res_t                 pt;
    int                   b, n;
    xs = '{t.v0_x, t.v1_x, t.v2_x};
    ys = '{t.v0_y, t.v1_y, t.v2_y};
    zs = '{t.v0_z, t.v1_z, t.v2_z};
    n = 0;
    for (int e = 0; e < 3; e++) begin
      b = (e == 2) ? 0 : e + 1;
      if ((zs[e] <= plane_z) != (zs[b] <= plane_z)) begin
        xa = xs[e];
        ya = ys[e];
        za = zs[e];
        dx = xs[b];
        dy = ys[b];
        dz = zs[b];
        dx = dx - xa;
        dy = dy - ya;
        dz = dz - za;
        diff = plane_z;
        diff = diff - za;
        pt.cut_x = CW'(xa + (dx * diff) / dz);
        pt.cut_y = CW'(ya + (dy * diff) / dz);
        pt.edge_index = (e == 0) ? EDGE_01 : (e == 1) ? EDGE_12 : EDGE_20;
        pt.last_of_triangle = 1'b0;
        add_pt(pt);
        n++;
      end
    end
    if (n > 0) cut_pts_q[$].last_of_triangle = 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one triangle and hold it until the transfer happens.
  task automatic send_tri(tri_t t, int n_typed, res_t p0, res_t p1);
    repeat (gap_len()) @(negedge clk);
    in_push = 1'b1;
    in_data = t;
    do @(posedge clk); while (in_full);
    if (n_typed < 0) begin
      slice_tri(t);
    end else begin
      if (n_typed > 0) add_pt(p0);
      if (n_typed > 1) add_pt(p1);
    end
    tris_sent++;
    @(negedge clk);
    in_push = 1'b0;
  endtask

  function automatic logic [CW-1:0] near_plane();
    longint v;
    if ($urandom_range(0, 3) == 0) return $urandom;
    v = longint'(plane_z) + $signed($urandom_range(0, 2_000_000)) - 1_000_000;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return CW'(v);
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    if ($urandom_range(0, 2) == 0) return CW'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
    return $urandom;
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    t.v0_x = rand_coord(); t.v0_y = rand_coord(); t.v0_z = near_plane();
    t.v1_x = rand_coord(); t.v1_y = rand_coord(); t.v1_z = near_plane();
    t.v2_x = rand_coord(); t.v2_y = rand_coord(); t.v2_z = near_plane();
    return t;
  endfunction

  // Drain all points, then let no-cut triangles still in flight clear.
  task automatic drain();
    while (cut_pts_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_plane(logic [CW-1:0] h);
    cfg_we   = 1'b1;
    cfg_data = h;
    plane_z  = h;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Receiver: random pop gaps, plus a long hold when asked.
  initial begin
    int gap;
    out_pop = 1'b0;
    gap = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_pop = 1'b0;
        repeat (400) @(negedge clk);
        hold_out = 1'b0;
      end
      out_pop = (gap == 0);
      if (gap > 0) gap--;
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (cut_pts_q.size() == 0) begin
          $display("ERROR %0t: unexpected point x=%0d y=%0d", $time,
                   out_data.cut_x, out_data.cut_y);
          errors++;
        end else begin
          res_t want;
          want = cut_pts_q.pop_front();
          if (out_data.cut_x !== want.cut_x)
            mismatch("cut_x", out_data.cut_x, want.cut_x);
          if (out_data.cut_y !== want.cut_y)
            mismatch("cut_y", out_data.cut_y, want.cut_y);
          if (out_data.edge_index !== want.edge_index)
            mismatch("edge_index", out_data.edge_index, want.edge_index);
          if (out_data.last_of_triangle !== want.last_of_triangle)
            mismatch("last_of_triangle", out_data.last_of_triangle,
                     want.last_of_triangle);
        end
        pts_checked++;
        gap = gap_len();
      end
    end
  end

  initial begin
    dir_row_t       rows[$];
    dir_row_t       r;
    logic [CW-1:0]  planes[$];
    res_t           none;
    int             n_items;

    clk = 1'b0; rst_n = 1'b0; cfg_we = 1'b0; cfg_data = '0;
    in_push = 1'b0; in_data = '0;
    errors = 0; tris_sent = 0; pts_checked = 0;
    hold_out = 1'b0; quiet = 1'b0; plane_z = '0; none = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Plane at reset height: below, above, touching, and simple crossings.
    r.pt0 = none; r.pt1 = none;
    r.n_pts = 0;
    r.tri_in = '{1, 2, -5, 3, 4, -6, 5, 6, 0};              // all at or below
    rows = {rows, r};
    r.tri_in = '{1, 2, 5, 3, 4, 6, 5, 6, 1};                // all above
    rows = {rows, r};
    r.n_pts = 2;
    r.tri_in = '{0, 0, -65536, 131072, 262144, 65536, 0, 262144, 65536};
    r.pt0 = '{65536, 131072, EDGE_01, 1'b0};
    r.pt1 = '{0, 131072, EDGE_20, 1'b1};
    rows = {rows, r};
    r.n_pts = -1;
    r.tri_in = '{32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0};
    rows = {rows, r};
    r.tri_in = '{32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000, 7, -7, 1};
    rows = {rows, r};
    r.tri_in = '{-3, 9, 1, 8, -2, 0, 4, 4, 2};              // v1 on the plane
    rows = {rows, r};
    r.tri_in = '{100, 200, 0, -100, 50, 0, 10, 10, 1};      // flat edge on plane
    rows = {rows, r};
    r.tri_in = '{5, 5, 3, -9, 17, -4, 1000, -1000, -1};     // crosses v0-v1 and v2-v0
    rows = {rows, r};
    r.tri_in = '{-77, 31, -1, 12345, -54321, 3, 0, 0, 9};
    rows = {rows, r};

    set_plane('0);
    foreach (rows[i]) send_tri(rows[i].tri_in, rows[i].n_pts, rows[i].pt0, rows[i].pt1);
    drain();

    planes = '{32'h0, 32'h7fffffff, 32'h80000000, $urandom, $urandom,
               32'h00010000, $urandom, $urandom};
    foreach (planes[p]) begin
      set_plane(planes[p]);
      quiet = (p % 3 == 2);
      n_items = (p == 1 || p == 2) ? 80 : 247;
      for (int i = 0; i < n_items; i++) begin
        tri_t t;
        t = rand_tri();
        if (p == 2 && i < 10) t.v0_z = 32'h80000000;   // lowest z sits on plane
        if (p == 4 && i == 20) begin
          quiet = 1'b1;
          hold_out = 1'b1;    // receiver stalls while triangles keep coming
        end
        if (p == 4 && i == 120) quiet = 1'b0;
        send_tri(t, -1, none, none);
      end
      drain();
    end

    $display("Sent %0d triangles over %0d plane heights, checked %0d points.",
             tris_sent, planes.size() + 1, pts_checked);
    $display("Covered extreme coordinates and planes, on-plane vertices and stalls.");
    if (errors == 0) begin
      $display("** triangle_plane_intersect: PASSED **");
    end else begin
      $display("** triangle_plane_intersect: FAILED **");
    end
    $finish;
  end

endmodule
